// ===== src/idwf_pkg.sv =====
// Package for the I2C display write framer.
// Holds the bus symbol codes, the framing constants and the types used by
// the top level, the front end, the frame queue and the bit sequencer.
`default_nettype none

package idwf_pkg;

    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_ACK   = 2'd2;
    localparam logic [1:0] SYM_STOP  = 2'd3;

    localparam logic       WRITE_BIT    = 1'b0;
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    localparam logic [6:0] ADDR_RESET = 7'd60;

    // Bits per byte before the acknowledge slot, and the index of the last byte.
    localparam logic [3:0] ACK_SLOT  = 4'd8;
    localparam logic [1:0] LAST_BYTE = 2'd2;

    // One fully classified transaction: the three bytes in bus order.
    typedef struct packed {
        logic [7:0] addr_byte;
        logic [7:0] ctrl_byte;
        logic [7:0] payload;
    } frame_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BITS,
        PH_STOP
    } phase_t;

endpackage

`default_nettype wire

// ===== src/i2c_display_write_framer.sv =====
// Top level of the I2C display write framer.
// Ties the front end, the frame queue and the bit sequencer together and
// holds the slave address register. Depends on idwf_pkg and its submodules.
`default_nettype none

// Each input beat (kind, value) becomes one complete I2C write transaction
// of exactly 29 output beats: a start, the address byte (slave address in
// the upper seven bits, write bit 0), the control byte (0x00 for a command,
// 0x40 for display data) and the payload byte, each sent MSB first and
// followed by an ack slot, then a stop flagged by last. Start, ack and stop
// beats report sda_level 1; acknowledges are clocked but never sampled.
// The bit sequencer emits one symbol per cycle while the output is not
// stalled, and a new transaction's start is the next output beat after
// the previous stop whenever a frame is waiting in the queue. The
// front end registers and classifies input beats into a two-entry frame
// queue, so up to four items can be taken while the output is stalled: one
// in the sequencer, two in the queue and one in the front end.
// An input moves through the front-end register, a queue entry and the
// output register. The slave address resets to 60 and is written through
// the configuration channel, which is always ready; only the low seven bits
// are kept, and a write should be made only while the block is idle.
module i2c_display_write_framer
    import idwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       kind,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      symbol,
    output logic            sda_level,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data
);

    logic [6:0]    slave_addr_reg;
    logic          push;
    logic          pop;
    frame_t        push_frame;
    frame_t        head;
    queue_status_t q_status;

    assign cfg_ready = 1'b1;

    // The address register takes a write on any configuration beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= ADDR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slave_addr_reg <= cfg_data;
        end
    end

    // The front end captures the address with each beat, so the frame in the
    // queue is complete and the sequencer needs no configuration.
    idwf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .value      (value),
        .slave_addr (slave_addr_reg),
        .queue_full (q_status.full),
        .push       (push),
        .push_frame (push_frame)
    );

    idwf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // The sequencer drives the output register and pops a frame only in the
    // cycle it loads that frame's start symbol into the output register.
    idwf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .queue_not_empty (q_status.not_empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .symbol          (symbol),
        .sda_level       (sda_level),
        .last            (last)
    );

endmodule

`default_nettype wire

// ===== src/idwf_front.sv =====
// Front end of the I2C display write framer.
// Accepts input beats, registers them and builds the three-byte frame.
// Depends on idwf_pkg.
`default_nettype none

module idwf_front
    import idwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       kind,
    input  wire logic [7:0] value,
    input  wire logic [6:0] slave_addr,
    input  wire logic       queue_full,
    output logic            push,
    output frame_t          push_frame
);

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;
    frame_t frame_next;
    logic   take;

    // The held beat leaves whenever the queue has room.
    assign push     = valid_reg && !queue_full;
    assign in_stall = valid_reg && queue_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        frame_next = frame_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next           = 1'b1;
            frame_next.addr_byte = {slave_addr, WRITE_BIT};
            frame_next.ctrl_byte = kind ? CTRL_DATA : CTRL_COMMAND;
            frame_next.payload   = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign push_frame = frame_reg;

endmodule

`default_nettype wire

// ===== src/idwf_queue.sv =====
// Two-entry frame queue of the I2C display write framer.
// Decouples the front end from the bit sequencer. Depends on idwf_pkg.
`default_nettype none

module idwf_queue
    import idwf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire frame_t push_frame,
    input  wire logic   pop,
    output frame_t      head,
    output queue_status_t status
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.full      = (count_reg == 2'd2);
    assign status.not_empty = (count_reg != 2'd0);

endmodule

`default_nettype wire

// ===== src/idwf_back.sv =====
// Bit sequencer of the I2C display write framer.
// Turns one queued frame into start, 27 bit and ack symbols and a stop,
// one symbol per beat into an output register. Depends on idwf_pkg.
`default_nettype none

module idwf_back
    import idwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire frame_t     head,
    input  wire logic       queue_not_empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      symbol,
    output logic            sda_level,
    output logic            last
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  bit_cnt_reg;
    logic [3:0]  bit_cnt_next;
    logic [1:0]  byte_cnt_reg;
    logic [1:0]  byte_cnt_next;
    logic [23:0] shift_reg;
    logic [23:0] shift_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  symbol_reg;
    logic [1:0]  symbol_next;
    logic        sda_reg;
    logic        sda_next;
    logic        last_reg;
    logic        last_next;
    logic        advance;

    // The output register may take a new symbol when empty or being drained.
    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        sda_next       = sda_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (queue_not_empty)
                    begin
                        pop            = 1'b1;
                        shift_next     = head;
                        bit_cnt_next   = 4'd0;
                        byte_cnt_next  = 2'd0;
                        phase_next     = PH_BITS;
                        out_valid_next = 1'b1;
                        symbol_next    = SYM_START;
                        sda_next       = 1'b1;
                        last_next      = 1'b0;
                    end
                end
                PH_BITS:
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    if (bit_cnt_reg == ACK_SLOT)
                    begin
                        symbol_next   = SYM_ACK;
                        sda_next      = 1'b1;
                        bit_cnt_next  = 4'd0;
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                        if (byte_cnt_reg == LAST_BYTE)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    else
                    begin
                        symbol_next  = SYM_BIT;
                        sda_next     = shift_reg[23];
                        shift_next   = {shift_reg[22:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                    end
                end
                PH_STOP:
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = SYM_STOP;
                    sda_next       = 1'b1;
                    last_next      = 1'b1;
                    phase_next     = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg  <= bit_cnt_next;
        byte_cnt_reg <= byte_cnt_next;
        shift_reg    <= shift_next;
        symbol_reg   <= symbol_next;
        sda_reg      <= sda_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign sda_level = sda_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
